@@ rtl/fmpf_pkg.sv @@
package fmpf_pkg;

	localparam int RULE_SLOTS_DEF = 16;

	localparam logic [1:0] CMD_CHECK  = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BAD_ID = 2'd2;

	localparam logic [1:0] CFG_ENABLE     = 2'd0;
	localparam logic [1:0] CFG_DFLT_IN    = 2'd1;
	localparam logic [1:0] CFG_DFLT_OUT   = 2'd2;

	typedef struct packed {
		logic load;
		logic commit;
	} fmpf_cmd_t;

endpackage

@@ rtl/fmpf_ctrl.sv @@
module fmpf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output fmpf_pkg::fmpf_cmd_t dp_cmd
);
	import fmpf_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RES  = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic accept;
	logic fire;

	always_comb begin
		accept = in_valid && (state_q == S_IDLE);
		fire   = (state_q == S_RES) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_RES;
				end
				S_RES: begin
					if (fire)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;
	assign dp_cmd.load   = accept;
	assign dp_cmd.commit = fire;

endmodule

@@ rtl/fmpf_dp.sv @@
module fmpf_dp #(
	parameter int NSLOT = fmpf_pkg::RULE_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fmpf_pkg::fmpf_cmd_t dp_cmd,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic                cfg_data,
	input  logic [1:0]          cmd,
	input  logic                dir,
	input  logic                verdict_allow,
	input  logic [7:0]          proto,
	input  logic [31:0]         src_addr,
	input  logic [31:0]         src_addr_mask,
	input  logic [31:0]         dst_addr,
	input  logic [31:0]         dst_addr_mask,
	input  logic [15:0]         src_port_num,
	input  logic [15:0]         dst_port_num,
	input  logic [7:0]          rule_id,
	output logic                allow,
	output logic [1:0]          status,
	output logic [3:0]          slot,
	output logic [31:0]         drops_in,
	output logic [31:0]         drops_out
);
	import fmpf_pkg::*;

	localparam int IW = (NSLOT > 1) ? $clog2(NSLOT) : 1;

	// configuration
	logic en_q, dflt_in_q, dflt_out_q;

	// item under resolution
	logic [1:0]  cmd_q;
	logic        dir_q;
	logic        act_q;
	logic [7:0]  proto_q;
	logic [31:0] sa_q, sm_q, da_q, dm_q;
	logic [15:0] sp_q, dp_q;
	logic [7:0]  id_q;
	logic [NSLOT-1:0] hit_q;

	// rule table
	logic [NSLOT-1:0] valid_q;
	logic [NSLOT-1:0] rdir_q;
	logic [NSLOT-1:0] rallow_q;
	logic [7:0]  rproto_q [NSLOT];
	logic [31:0] rsa_q [NSLOT];
	logic [31:0] rsm_q [NSLOT];
	logic [31:0] rda_q [NSLOT];
	logic [31:0] rdm_q [NSLOT];
	logic [15:0] rsp_q [NSLOT];
	logic [15:0] rdp_q [NSLOT];

	logic [NSLOT-1:0] lane_hit;
	logic [NSLOT-1:0] hit_oh;
	logic [NSLOT-1:0] free_oh;
	logic [NSLOT-1:0] rem_sel;
	logic [IW-1:0]    free_idx;
	logic             full;
	logic             id_ok;
	logic             verdict;
	logic [1:0]       status_d;
	logic [3:0]       slot_d;
	logic             do_add, do_rem, do_drop;

	logic [31:0] drops_in_q, drops_out_q;
	logic        allow_q;
	logic [1:0]  status_q;
	logic [3:0]  slot_q;

	genvar g;
	generate
		for (g = 0; g < NSLOT; g++) begin : g_lane
			assign lane_hit[g] = valid_q[g] && (rdir_q[g] == dir)
				&& ((rproto_q[g] == 8'd0) || (rproto_q[g] == proto))
				&& (((src_addr ^ rsa_q[g]) & rsm_q[g]) == 32'd0)
				&& (((dst_addr ^ rda_q[g]) & rdm_q[g]) == 32'd0)
				&& ((rsp_q[g] == 16'd0) || (rsp_q[g] == src_port_num))
				&& ((rdp_q[g] == 16'd0) || (rdp_q[g] == dst_port_num));
			assign rem_sel[g] = ({1'b0, id_q} == 9'(g));

			always_ff @(posedge clk) begin
				if (do_add && free_oh[g]) begin
					rdir_q[g]   <= dir_q;
					rallow_q[g] <= act_q;
					rproto_q[g] <= proto_q;
					rsa_q[g]    <= sa_q;
					rsm_q[g]    <= sm_q;
					rda_q[g]    <= da_q;
					rdm_q[g]    <= dm_q;
					rsp_q[g]    <= sp_q;
					rdp_q[g]    <= dp_q;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					valid_q[g] <= 1'b0;
				else if (do_add && free_oh[g])
					valid_q[g] <= 1'b1;
				else if (do_rem && rem_sel[g])
					valid_q[g] <= 1'b0;
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q   <= cmd;
			dir_q   <= dir;
			act_q   <= verdict_allow;
			proto_q <= proto;
			sa_q    <= src_addr;
			sm_q    <= src_addr_mask;
			da_q    <= dst_addr;
			dm_q    <= dst_addr_mask;
			sp_q    <= src_port_num;
			dp_q    <= dst_port_num;
			id_q    <= rule_id;
			hit_q   <= lane_hit;
		end
	end

	always_comb begin
		hit_oh  = hit_q & (~hit_q + NSLOT'(1));
		free_oh = ~valid_q & (valid_q + NSLOT'(1));
		full    = &valid_q;
		free_idx = '0;
		for (int k = 0; k < NSLOT; k++)
			if (free_oh[k])
				free_idx = free_idx | IW'(k);
		id_ok = |(valid_q & rem_sel);

		if (!en_q)
			verdict = 1'b1;
		else if (|hit_q)
			verdict = |(hit_oh & rallow_q);
		else
			verdict = dir_q ? dflt_out_q : dflt_in_q;

		status_d = ST_OK;
		slot_d   = 4'd0;
		case (cmd_q)
			CMD_ADD: begin
				if (full)
					status_d = ST_FULL;
				else
					slot_d = 4'(free_idx);
			end
			CMD_REMOVE: begin
				if (!id_ok)
					status_d = ST_BAD_ID;
			end
			default: status_d = ST_OK;
		endcase

		do_add  = dp_cmd.commit && (cmd_q == CMD_ADD) && !full;
		do_rem  = dp_cmd.commit && (cmd_q == CMD_REMOVE);
		do_drop = dp_cmd.commit && (cmd_q == CMD_CHECK) && !verdict;
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.commit) begin
			allow_q  <= (cmd_q == CMD_CHECK) && verdict;
			status_q <= status_d;
			slot_q   <= slot_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= 1'b0;
			dflt_in_q   <= 1'b1;
			dflt_out_q  <= 1'b1;
			drops_in_q  <= 32'd0;
			drops_out_q <= 32'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLE:   en_q       <= cfg_data;
					CFG_DFLT_IN:  dflt_in_q  <= cfg_data;
					CFG_DFLT_OUT: dflt_out_q <= cfg_data;
					default: ;
				endcase
			end
			if (do_drop) begin
				if (dir_q)
					drops_out_q <= drops_out_q + 32'd1;
				else
					drops_in_q <= drops_in_q + 32'd1;
			end
		end
	end

	assign allow     = allow_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign drops_in  = drops_in_q;
	assign drops_out = drops_out_q;

endmodule

@@ rtl/first_match_packet_filter_core.sv @@
// First-match five-tuple packet filter.
// Input channel (in_valid/in_stall) carries one command per transaction:
// check a packet header, add a rule, or remove a rule by id.
// Output channel (out_valid/out_stall) returns one result per transaction:
// verdict, status, slot taken by an add, and both drop counters.
// Every rule slot has its own compare lane, evaluated as the transaction is
// accepted; the resolve step then priority-encodes the hits, updates the
// table and counters and loads the output register, which raises out_valid.
// The block takes no new transaction while one is in the resolve step, as
// set by the accept / resolve sequence of the controller.
// A new transaction is accepted while a result waits in the output register;
// it is held in the resolve step until that result is taken.
// cfg_we writes one configuration bit (enable, inbound default, outbound
// default) per cycle; write only while the block is idle.
// Reset clears all rule valid bits and both drop counters, disables
// filtering and sets both defaults to allow. No clearing pass is needed.
module first_match_packet_filter_core #(
	parameter int RULE_SLOTS = fmpf_pkg::RULE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic        dir,
	input  logic        verdict_allow,
	input  logic [7:0]  proto,
	input  logic [31:0] src_addr,
	input  logic [31:0] src_addr_mask,
	input  logic [31:0] dst_addr,
	input  logic [31:0] dst_addr_mask,
	input  logic [15:0] src_port_num,
	input  logic [15:0] dst_port_num,
	input  logic [7:0]  rule_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        allow,
	output logic [1:0]  status,
	output logic [3:0]  slot,
	output logic [31:0] drops_in,
	output logic [31:0] drops_out
);
	import fmpf_pkg::*;

	fmpf_cmd_t dp_cmd;

	fmpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd)
	);

	fmpf_dp #(
		.NSLOT (RULE_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.dp_cmd        (dp_cmd),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.dir           (dir),
		.verdict_allow (verdict_allow),
		.proto         (proto),
		.src_addr      (src_addr),
		.src_addr_mask (src_addr_mask),
		.dst_addr      (dst_addr),
		.dst_addr_mask (dst_addr_mask),
		.src_port_num  (src_port_num),
		.dst_port_num  (dst_port_num),
		.rule_id       (rule_id),
		.allow         (allow),
		.status        (status),
		.slot          (slot),
		.drops_in      (drops_in),
		.drops_out     (drops_out)
	);

`ifndef ASSERT_OFF
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted transaction did not enter resolve");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_BAD_ID))
		else $error("undefined status code");

	a_allow_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && allow |-> status == ST_OK && slot == 4'd0)
		else $error("allow verdict with non-check result fields");

	a_drops_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |=> $stable(drops_in) && $stable(drops_out))
		else $error("drop counter moved outside resolve");
`endif

endmodule

@@ tb/sv/first_match_packet_filter_core_test.sv @@
`timescale 1ns / 1ps

module first_match_packet_filter_core_test;
	import fmpf_pkg::*;

	localparam logic [1:0] CMD_RSVD = 2'd3;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 110;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        dir;
		logic        act;
		logic [7:0]  proto;
		logic [31:0] sa;
		logic [31:0] sm;
		logic [31:0] da;
		logic [31:0] dm;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [7:0]  id;
	} filter_cmd_t;

	typedef struct packed {
		logic        allow;
		logic [1:0]  status;
		logic [3:0]  slot;
		logic [31:0] drops_in;
		logic [31:0] drops_out;
	} filter_result_t;

	typedef struct packed {
		logic        valid;
		logic        dir;
		logic        act;
		logic [7:0]  proto;
		logic [31:0] sa;
		logic [31:0] sm;
		logic [31:0] da;
		logic [31:0] dm;
		logic [15:0] sp;
		logic [15:0] dp;
	} rule_entry_t;

	// cfg bits: {default_allow_out, default_allow_in, filter_enable}
	typedef struct {
		bit             reconf;
		logic [2:0]     cfg;
		filter_cmd_t    item;
		int             count;
		bit             fixed;
		filter_result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_ENABLE;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_CHECK;
	logic        dir = 1'b0;
	logic        verdict_allow = 1'b0;
	logic [7:0]  proto = '0;
	logic [31:0] src_addr = '0;
	logic [31:0] src_addr_mask = '0;
	logic [31:0] dst_addr = '0;
	logic [31:0] dst_addr_mask = '0;
	logic [15:0] src_port_num = '0;
	logic [15:0] dst_port_num = '0;
	logic [7:0]  rule_id = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        allow;
	logic [1:0]  status;
	logic [3:0]  slot;
	logic [31:0] drops_in;
	logic [31:0] drops_out;

	// predictor state
	rule_entry_t rule_tbl [RULE_SLOTS_DEF];
	logic [31:0] drop_cnt_in = '0;
	logic [31:0] drop_cnt_out = '0;
	logic        flt_en = 1'b0;
	logic        dflt_in = 1'b1;
	logic        dflt_out = 1'b1;

	filter_result_t pending_verdicts [$];
	logic           row_fixed = 1'b0;
	filter_result_t row_want = '0;

	int sent_count = 0;
	int results_seen = 0;
	int errs = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int cfg_loads = 0;
	int n_check = 0, n_drop = 0, n_add = 0, n_full = 0, n_remove = 0, n_bad = 0, n_rsvd = 0;

	first_match_packet_filter_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.dir(dir),
		.verdict_allow(verdict_allow),
		.proto(proto),
		.src_addr(src_addr),
		.src_addr_mask(src_addr_mask),
		.dst_addr(dst_addr),
		.dst_addr_mask(dst_addr_mask),
		.src_port_num(src_port_num),
		.dst_port_num(dst_port_num),
		.rule_id(rule_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.allow(allow),
		.status(status),
		.slot(slot),
		.drops_in(drops_in),
		.drops_out(drops_out)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		for (int k = 0; k < RULE_SLOTS_DEF; k++) rule_tbl[k] = '0;
	end

	function automatic filter_result_t filter_predict(input filter_cmd_t c);
		filter_result_t r;
		int hit;
		r = '0;
		hit = -1;
		case (c.cmd)
			CMD_CHECK: begin
				if (!flt_en) begin
					r.allow = 1'b1;
				end else begin
					r.allow = c.dir ? dflt_out : dflt_in;
					// scan downward so the lowest matching slot wins
					for (int k = RULE_SLOTS_DEF - 1; k >= 0; k--) begin
						if (rule_tbl[k].valid && rule_tbl[k].dir == c.dir
								&& (rule_tbl[k].proto == 8'd0 || rule_tbl[k].proto == c.proto)
								&& ((c.sa ^ rule_tbl[k].sa) & rule_tbl[k].sm) == 32'd0
								&& ((c.da ^ rule_tbl[k].da) & rule_tbl[k].dm) == 32'd0
								&& (rule_tbl[k].sp == 16'd0 || rule_tbl[k].sp == c.sp)
								&& (rule_tbl[k].dp == 16'd0 || rule_tbl[k].dp == c.dp))
							hit = k;
					end
					if (hit >= 0) r.allow = rule_tbl[hit].act;
					if (!r.allow) begin
						if (c.dir) drop_cnt_out = drop_cnt_out + 32'd1;
						else drop_cnt_in = drop_cnt_in + 32'd1;
					end
				end
			end
			CMD_ADD: begin
				for (int k = RULE_SLOTS_DEF - 1; k >= 0; k--)
					if (!rule_tbl[k].valid) hit = k;
				if (hit < 0) begin
					r.status = ST_FULL;
				end else begin
					rule_tbl[hit] = {1'b1, c.dir, c.act, c.proto, c.sa, c.sm, c.da, c.dm,
						c.sp, c.dp};
					r.slot = 4'(hit);
				end
			end
			CMD_REMOVE: begin
				if (c.id >= RULE_SLOTS_DEF || !rule_tbl[c.id[3:0]].valid)
					r.status = ST_BAD_ID;
				else
					rule_tbl[c.id[3:0]].valid = 1'b0;
			end
			default: ;
		endcase
		r.drops_in = drop_cnt_in;
		r.drops_out = drop_cnt_out;
		return r;
	endfunction

	function automatic filter_cmd_t pkt_cmd(input logic [1:0] c, input logic d, input logic a,
			input logic [7:0] p, input logic [31:0] sa, input logic [31:0] sm,
			input logic [31:0] da, input logic [31:0] dm, input logic [15:0] sp,
			input logic [15:0] dp, input logic [7:0] id);
		return {c, d, a, p, sa, sm, da, dm, sp, dp, id};
	endfunction

	function automatic filter_result_t clean_result(input logic a, input logic [1:0] st,
			input logic [3:0] sl);
		return {a, st, sl, 32'd0, 32'd0};
	endfunction

	function automatic logic [31:0] prefix_mask(input int len);
		return (len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - len);
	endfunction

	task automatic issue_cmd(input filter_cmd_t it, input logic fx, input filter_result_t ex);
		bit lowered;
		lowered = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			if (!lowered) in_valid <= 1'b0;
			lowered = 1;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		dir <= it.dir;
		verdict_allow <= it.act;
		proto <= it.proto;
		src_addr <= it.sa;
		src_addr_mask <= it.sm;
		dst_addr <= it.da;
		dst_addr_mask <= it.dm;
		src_port_num <= it.sp;
		dst_port_num <= it.dp;
		rule_id <= it.id;
		row_fixed <= fx;
		row_want <= ex;
		do @(posedge clk); while (!(in_valid && !in_stall));
		sent_count++;
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (results_seen != sent_count) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input logic [2:0] bits);
		logic [1:0] idx [3];
		idx[0] = CFG_ENABLE;
		idx[1] = CFG_DFLT_IN;
		idx[2] = CFG_DFLT_OUT;
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= bits[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		flt_en = bits[0];
		dflt_in = bits[1];
		dflt_out = bits[2];
		cfg_loads++;
	endtask

	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin : monitor
		filter_result_t got;
		filter_result_t want;
		filter_result_t pred;
		filter_cmd_t cur;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				got = {allow, status, slot, drops_in, drops_out};
				if (pending_verdicts.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("unexpected result allow=%0d status=%0d slot=%0d in=%0d out=%0d",
							got.allow, got.status, got.slot, got.drops_in, got.drops_out);
				end else begin
					want = pending_verdicts.pop_front();
					if (got.allow != want.allow || got.status != want.status
							|| got.slot != want.slot || got.drops_in != want.drops_in
							|| got.drops_out != want.drops_out) begin
						errs++;
						if (errs <= 10)
							$display({"mismatch on result %0d: exp allow=%0d status=%0d slot=%0d ",
								"in=%0d out=%0d, got allow=%0d status=%0d slot=%0d in=%0d out=%0d"},
								results_seen, want.allow, want.status, want.slot, want.drops_in,
								want.drops_out, got.allow, got.status, got.slot, got.drops_in,
								got.drops_out);
					end
				end
			end
			if (in_valid && !in_stall) begin
				cur = {cmd, dir, verdict_allow, proto, src_addr, src_addr_mask, dst_addr,
					dst_addr_mask, src_port_num, dst_port_num, rule_id};
				pred = filter_predict(cur);
				case (cur.cmd)
					CMD_CHECK: begin
						n_check++;
						if (!pred.allow) n_drop++;
					end
					CMD_ADD: begin
						n_add++;
						if (pred.status == ST_FULL) n_full++;
					end
					CMD_REMOVE: begin
						n_remove++;
						if (pred.status == ST_BAD_ID) n_bad++;
					end
					default: n_rsvd++;
				endcase
				pending_verdicts.push_back(row_fixed ? row_want : pred);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", idle_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t rows [$];
		filter_cmd_t it;
		rule_entry_t base;
		int roll;
		int n_directed;
		filter_result_t none;
		none = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: filter off, both defaults allow
		rows.push_back('{0, 3'b000, pkt_cmd(CMD_CHECK, 1, 1, 8'hFF, '1, '1, '1, '1, '1, '1,
			8'hFF), 1, 1, clean_result(1, ST_OK, 0)});
		rows.push_back('{0, 3'b000, pkt_cmd(CMD_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
			clean_result(1, ST_OK, 0)});
		rows.push_back('{0, 3'b000, pkt_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hFF), 1, 1,
			clean_result(0, ST_BAD_ID, 0)});
		rows.push_back('{0, 3'b000, pkt_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd16), 1, 1,
			clean_result(0, ST_BAD_ID, 0)});
		rows.push_back('{0, 3'b000, pkt_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd0), 1, 1,
			clean_result(0, ST_BAD_ID, 0)});
		rows.push_back('{0, 3'b000, pkt_cmd(CMD_RSVD, 1, 1, 8'hFF, '1, '1, '1, '1, '1, '1, 8'hFF),
			1, 1, clean_result(0, ST_OK, 0)});
		rows.push_back('{0, 3'b000, pkt_cmd(CMD_ADD, 0, 0, 8'd6, 32'h0A00_0000, 32'hFF00_0000, 0,
			0, 0, 16'd80, 0), 1, 1, clean_result(0, ST_OK, 0)});
		rows.push_back('{0, 3'b000, pkt_cmd(CMD_ADD, 1, 1, 8'hFF, '1, '1, '1, '1, '1, '1, 8'hFF),
			1, 1, clean_result(0, ST_OK, 1)});
		rows.push_back('{0, 3'b000, pkt_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd1), 1, 1,
			clean_result(0, ST_OK, 0)});
		rows.push_back('{0, 3'b000, pkt_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd1), 1, 1,
			clean_result(0, ST_BAD_ID, 0)});
		rows.push_back('{0, 3'b000, pkt_cmd(CMD_ADD, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
			clean_result(0, ST_OK, 1)});
		rows.push_back('{0, 3'b000, pkt_cmd(CMD_ADD, 1, 1, 8'hFF, '1, '1, '1, '1, '1, '1, 0), 1, 1,
			clean_result(0, ST_OK, 2)});
		// filter on, both defaults deny
		rows.push_back('{1, 3'b001, pkt_cmd(CMD_CHECK, 0, 0, 8'd6, 32'h0A01_0203, 0,
			32'hC0A8_0001, 0, 16'h1234, 16'd80, 0), 1, 0, none});
		rows.push_back('{0, 3'b001, pkt_cmd(CMD_CHECK, 0, 0, 8'd17, 32'h0A01_0203, 0,
			32'hC0A8_0001, 0, 16'h1234, 16'd80, 0), 1, 0, none});
		rows.push_back('{0, 3'b001, pkt_cmd(CMD_CHECK, 1, 1, 8'hFF, '1, '1, '1, '1, '1, '1, 8'hFF),
			1, 0, none});
		rows.push_back('{0, 3'b001, pkt_cmd(CMD_CHECK, 1, 1, 8'hFF, '1, '1, '1, '1, 16'hFFFE, '1,
			8'hFF), 1, 0, none});
		rows.push_back('{0, 3'b001, pkt_cmd(CMD_CHECK, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none});
		// fill the table, then one add too many
		rows.push_back('{0, 3'b001, pkt_cmd(CMD_ADD, 1, 0, 8'd17, 32'hC0A8_0000, 32'hFFFF_0000, 0,
			0, 0, 16'd53, 0), 13, 0, none});
		rows.push_back('{0, 3'b001, pkt_cmd(CMD_ADD, 0, 1, 8'd1, '1, '1, '1, '1, '1, '1, 0), 1, 0,
			none});
		rows.push_back('{0, 3'b001, pkt_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd15), 1, 0,
			none});
		rows.push_back('{0, 3'b001, pkt_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd0), 1, 0,
			none});
		rows.push_back('{0, 3'b001, pkt_cmd(CMD_CHECK, 0, 0, 8'd6, 32'h0A01_0203, 0,
			32'hC0A8_0001, 0, 16'h1234, 16'd80, 0), 1, 0, none});
		// filter on, both defaults allow
		rows.push_back('{1, 3'b111, pkt_cmd(CMD_CHECK, 1, 0, 8'd17, 32'hC0A8_0101, 0,
			32'h0808_0808, 0, 16'd5000, 16'd53, 0), 1, 0, none});
		rows.push_back('{0, 3'b111, pkt_cmd(CMD_CHECK, 1, 0, 8'd6, 32'h0102_0304, 0,
			32'h0506_0708, 0, 16'd5000, 16'd443, 0), 1, 0, none});
		// filter off, inbound allow, outbound deny
		rows.push_back('{1, 3'b010, pkt_cmd(CMD_CHECK, 0, 1, 8'hFF, '1, '1, '1, '1, '1, '1, 8'hFF),
			1, 0, none});

		foreach (rows[r]) begin
			if (rows[r].reconf) begin
				wait_quiet();
				load_config(rows[r].cfg);
			end
			for (int n = 0; n < rows[r].count; n++)
				issue_cmd(rows[r].item, rows[r].fixed, rows[r].want);
		end
		n_directed = sent_count;
		wait_quiet();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 65; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 65; end
				default: begin send_idle_pct = 7; stall_pct = 7; end
			endcase
			load_config({1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(4) != 0)});
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				it = {2'($urandom), 1'($urandom), 1'($urandom), 8'($urandom), 32'($urandom),
					32'($urandom), 32'($urandom), 32'($urandom), 16'($urandom), 16'($urandom),
					8'($urandom)};
				roll = $urandom_range(99);
				if (roll < 58) begin
					it.cmd = CMD_CHECK;
					// most packets aimed at an existing rule, some with one bit off
					if ($urandom_range(99) < 65) begin
						base = rule_tbl[$urandom_range(RULE_SLOTS_DEF - 1)];
						it.dir = base.dir;
						if (base.proto != 8'd0) it.proto = base.proto;
						it.sa = (base.sa & base.sm) | (it.sa & ~base.sm);
						it.da = (base.da & base.dm) | (it.da & ~base.dm);
						if (base.sp != 16'd0) it.sp = base.sp;
						if (base.dp != 16'd0) it.dp = base.dp;
						if ($urandom_range(6) == 0) it.sa = it.sa ^ (32'h1 << $urandom_range(31));
						if ($urandom_range(9) == 0) it.dp = it.dp ^ 16'h1;
					end
				end else if (roll < 78) begin
					it.cmd = CMD_ADD;
					case ($urandom_range(3))
						0: it.proto = 8'd0;
						1: it.proto = 8'd6;
						2: it.proto = 8'd17;
						default: ;
					endcase
					if ($urandom_range(4) != 0) it.sm = prefix_mask($urandom_range(32));
					if ($urandom_range(4) != 0) it.dm = prefix_mask($urandom_range(32));
					if ($urandom_range(1)) it.sa[31:24] = 8'd10;
					if ($urandom_range(1)) it.sp = 16'd0;
					case ($urandom_range(2))
						0: it.dp = 16'd0;
						1: it.dp = 16'd80;
						default: ;
					endcase
				end else if (roll < 97) begin
					it.cmd = CMD_REMOVE;
					if ($urandom_range(4) != 0) it.id = 8'($urandom_range(RULE_SLOTS_DEF - 1));
				end else begin
					it.cmd = CMD_RSVD;
				end
				issue_cmd(it, 1'b0, none);
			end
			wait_quiet();
		end

		if (pending_verdicts.size() != 0) begin
			$display("%0d expected results never arrived", pending_verdicts.size());
			errs += pending_verdicts.size();
		end
		$display("covered %0d transactions (%0d directed, %0d random) over %0d register settings",
			sent_count, n_directed, sent_count - n_directed, cfg_loads);
		$display("checks %0d (%0d dropped), adds %0d (%0d full), removes %0d (%0d bad id), %0d %s",
			n_check, n_drop, n_add, n_full, n_remove, n_bad, n_rsvd, "unused code; errors below");
		$display("mismatches: %0d", errs);
		if (errs == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
